// ===== sv/egcd_pkg.sv =====
`default_nettype none

package egcd_pkg;

  // Field widths of the request and result channels
  localparam int OPERAND_W = 63;
  localparam int DIVISOR_W = 63;
  localparam int COEFF_W   = 64;

  // Input request: two non-negative operands
  typedef struct packed {
    logic [OPERAND_W-1:0] first_operand;
    logic [OPERAND_W-1:0] second_operand;
  } in_t;

  // Result: gcd and Bezout coefficients, first*coeff_first + second*coeff_second = divisor
  typedef struct packed {
    logic [DIVISOR_W-1:0]      divisor;
    logic signed [COEFF_W-1:0] coeff_first;
    logic signed [COEFF_W-1:0] coeff_second;
  } out_t;

endpackage

`default_nettype wire

// ===== sv/egcd_qstore.sv =====
`default_nettype none

// Quotient store: one write port, one registered read port
module egcd_qstore #(
  parameter int DATA_W = 63,
  parameter int DEPTH  = 132,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/egcd_core.sv =====
`default_nettype none

// Sequencer around one shared subtractor.
// Forward pass: restoring division, one quotient bit per cycle, quotients pushed to the store.
// Back pass: quotients popped in reverse, nx = cy - q*cx by shift-and-subtract.
module egcd_core #(
  parameter int W = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire egcd_pkg::in_t req,
  output logic               idle,
  output logic               done,
  input  wire logic          take,
  output egcd_pkg::out_t     res
);
  import egcd_pkg::*;

  localparam int NB = W - 1;               // operand bits
  localparam int QS = 2 * W + 4;           // quotient store entries
  localparam int AW = $clog2(QS);
  localparam int DW = $clog2(QS + 1);
  localparam int CW = $clog2(NB);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_STEP  = 3'd3;
  localparam logic [2:0] ST_BACK  = 3'd4;
  localparam logic [2:0] ST_LOAD  = 3'd5;
  localparam logic [2:0] ST_MUL   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [NB-1:0] ra_r, ra_nxt;       // divisor of the current step
  logic [NB-1:0] rb_r, rb_nxt;       // dividend; holds gcd at the end
  logic [NB-1:0] rem_r, rem_nxt;
  logic [NB-1:0] quo_r, quo_nxt;     // dividend bits out, quotient bits in
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [W-1:0]  cx_r, cx_nxt;
  logic [W-1:0]  cy_r, cy_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  mcand_r, mcand_nxt;
  logic [NB-1:0] mplier_r, mplier_nxt;

  // shared subtractor
  logic [W-1:0] sub_x, sub_y;
  logic [W:0]   sub_d;
  logic         sub_borrow;

  // quotient store ports
  logic          mem_we;
  logic [DW-1:0] depth_dec;
  logic [NB-1:0] mem_rdata;

  always_comb begin
    sub_x = acc_r;
    sub_y = mcand_r;
    if (state_r == ST_DIV) begin
      sub_x = {rem_r, quo_r[NB-1]};
      sub_y = {1'b0, ra_r};
    end
  end

  assign sub_d      = {1'b0, sub_x} - {1'b0, sub_y};
  assign sub_borrow = sub_d[W];

  assign mem_we    = (state_r == ST_STEP) && (depth_r < DW'(QS));
  assign depth_dec = depth_r - DW'(1);

  egcd_qstore #(
    .DATA_W(NB),
    .DEPTH (QS),
    .ADDR_W(AW)
  ) u_qstore (
    .clk  (clk),
    .we   (mem_we),
    .waddr(depth_r[AW-1:0]),
    .wdata(quo_r),
    .raddr(depth_dec[AW-1:0]),
    .rdata(mem_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    ra_nxt     = ra_r;
    rb_nxt     = rb_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    cnt_nxt    = cnt_r;
    depth_nxt  = depth_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ra_nxt    = req.first_operand[NB-1:0];
          rb_nxt    = req.second_operand[NB-1:0];
          depth_nxt = '0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (ra_r == '0) begin
          cx_nxt    = '0;
          cy_nxt    = W'(1);
          state_nxt = ST_BACK;
        end else begin
          rem_nxt   = '0;
          quo_nxt   = rb_r;
          cnt_nxt   = CW'(NB - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // one restoring step: trial = {rem, next dividend bit}
        if (!sub_borrow) begin
          rem_nxt = sub_d[NB-1:0];
        end else begin
          rem_nxt = {rem_r[NB-2:0], quo_r[NB-1]};
        end
        quo_nxt = {quo_r[NB-2:0], ~sub_borrow};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        // quotient written this cycle; drop it when the store is full
        if (depth_r < DW'(QS)) begin
          depth_nxt = depth_r + DW'(1);
        end
        rb_nxt    = ra_r;
        ra_nxt    = rem_r;
        state_nxt = ST_CHECK;
      end
      ST_BACK: begin
        if (depth_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          depth_nxt = depth_dec;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        mplier_nxt = mem_rdata;
        mcand_nxt  = cx_r;
        acc_nxt    = cy_r;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        // acc = cy - q*cx, one multiplier bit per cycle, ends early
        if (mplier_r == '0) begin
          cy_nxt    = cx_r;
          cx_nxt    = acc_r;
          state_nxt = ST_BACK;
        end else begin
          if (mplier_r[0]) begin
            acc_nxt = sub_d[W-1:0];
          end
          mplier_nxt = mplier_r >> 1;
          mcand_nxt  = mcand_r << 1;
        end
      end
      ST_DONE: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ra_r     <= ra_nxt;
    rb_r     <= rb_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    depth_r  <= depth_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  // status and result
  assign idle             = (state_r == ST_IDLE);
  assign done             = (state_r == ST_DONE);
  assign res.divisor      = DIVISOR_W'(rb_r);
  assign res.coeff_first  = COEFF_W'($signed(cx_r));
  assign res.coeff_second = COEFF_W'($signed(cy_r));

endmodule

`default_nettype wire

// ===== sv/extended_gcd_engine_top.sv =====
// Extended Euclid engine: gcd(a, b) with Bezout coefficients x, y, a*x + b*y = gcd.
//
// Request channel in_valid / in_stall / in_req carries the two operands; only the low
// OPERAND_BITS-1 bits of each are used. A request is taken when in_valid is high and
// in_stall is low. Result channel out_valid / out_stall / out_req returns divisor,
// coeff_first and coeff_second (coefficients are OPERAND_BITS wide, sign-extended to 64).
//
// One request is in work at a time; in_stall stays high from acceptance until the
// result has moved into the output register. The forward pass produces one quotient
// bit per cycle in the shared subtractor; the reverse pass consumes one quotient bit
// per cycle in the same subtractor.
//
// The output register holds a finished result while out_stall is high; the engine
// accepts the next request meanwhile and waits in its final state only if it finishes
// again before that result is taken. Reset (rst_n low, synchronous) returns the
// sequencer to idle and empties the output register.
`default_nettype none

module extended_gcd_engine_top #(
  parameter int OPERAND_BITS = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire egcd_pkg::in_t  in_req,
  output logic                out_valid,
  input  wire logic           out_stall,
  output egcd_pkg::out_t      out_req
);
  import egcd_pkg::*;

  logic core_idle;
  logic core_done;
  logic core_take;
  out_t core_res;

  logic out_valid_r, out_valid_nxt;
  out_t out_req_r;

  egcd_core #(
    .W(OPERAND_BITS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .start(in_valid),
    .req  (in_req),
    .idle (core_idle),
    .done (core_done),
    .take (core_take),
    .res  (core_res)
  );

  assign in_stall = !core_idle;

  // output register: loads when empty or being drained
  assign core_take = core_done && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (core_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (core_take) begin
      out_req_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule

`default_nettype wire

// ===== sv/egcd_checker.sv =====
`default_nettype none

module egcd_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire egcd_pkg::in_t in_req,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire egcd_pkg::out_t out_req
);

  // an accepted request keeps the engine busy on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("engine ready right after taking a request");

  // no result can appear in the cycle after a request is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_req))
    else $error("stalled result changed");

  // zero gcd only from two zero operands: coefficients 0 and 1
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_req.divisor == '0) |->
      (out_req.coeff_first == '0) && (out_req.coeff_second == 64'sd1))
    else $error("bad coefficients for zero gcd");

  // a stalled request holds until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_req))
    else $error("stalled request changed");

endmodule

bind extended_gcd_engine_top egcd_checker u_egcd_checker (.*);

`default_nettype wire
